@@ hw/rtl/fng_pkg.sv @@
// ----------------------------------------------------------------------------
// fng_pkg
// Shared types, constants and the microcode program of the fraction reducer.
// ----------------------------------------------------------------------------
package fng_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int STEP_WIDTH = 4;

   typedef logic [STEP_WIDTH-1:0] step_type;

   // program counter locations
   localparam step_type STEP_WAIT      = 4'd0;
   localparam step_type STEP_TEST_NUM  = 4'd1;
   localparam step_type STEP_LOOP      = 4'd2;
   localparam step_type STEP_DIV_AB    = 4'd3;
   localparam step_type STEP_EUCLID    = 4'd4;
   localparam step_type STEP_DIV_NG    = 4'd5;
   localparam step_type STEP_SAVE_RN   = 4'd6;
   localparam step_type STEP_DIV_DG    = 4'd7;
   localparam step_type STEP_SAVE_RD   = 4'd8;
   localparam step_type STEP_EMIT      = 4'd9;
   localparam step_type STEP_EMIT_ZERO = 4'd10;

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_LOAD      = 4'd1,
      OP_DIV_AB    = 4'd2,
      OP_EUCLID    = 4'd3,
      OP_DIV_NG    = 4'd4,
      OP_SAVE_RN   = 4'd5,
      OP_DIV_DG    = 4'd6,
      OP_SAVE_RD   = 4'd7,
      OP_EMIT      = 4'd8,
      OP_EMIT_ZERO = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS   = 3'd0,
      COND_START    = 3'd1,
      COND_NUM_ZERO = 3'd2,
      COND_B_ZERO   = 3'd3,
      COND_DIV_DONE = 3'd4
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
      logic     hold;     // stay on this step while the condition is false
   } ctrl_word_type;

   typedef struct packed {
      logic start;
      logic num_zero;
      logic b_zero;
      logic div_done;
   } status_type;

   function automatic ctrl_word_type rom(input step_type pc);
      ctrl_word_type cw;
      cw = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_WAIT, hold: 1'b0};
      unique case (pc)
         STEP_WAIT:      cw = '{OP_LOAD,      COND_START,    STEP_TEST_NUM,  1'b1};
         STEP_TEST_NUM:  cw = '{OP_NONE,      COND_NUM_ZERO, STEP_EMIT_ZERO, 1'b0};
         STEP_LOOP:      cw = '{OP_NONE,      COND_B_ZERO,   STEP_DIV_NG,    1'b0};
         STEP_DIV_AB:    cw = '{OP_DIV_AB,    COND_ALWAYS,   STEP_EUCLID,    1'b0};
         STEP_EUCLID:    cw = '{OP_EUCLID,    COND_DIV_DONE, STEP_LOOP,      1'b1};
         STEP_DIV_NG:    cw = '{OP_DIV_NG,    COND_ALWAYS,   STEP_SAVE_RN,   1'b0};
         STEP_SAVE_RN:   cw = '{OP_SAVE_RN,   COND_DIV_DONE, STEP_DIV_DG,    1'b1};
         STEP_DIV_DG:    cw = '{OP_DIV_DG,    COND_ALWAYS,   STEP_SAVE_RD,   1'b0};
         STEP_SAVE_RD:   cw = '{OP_SAVE_RD,   COND_DIV_DONE, STEP_EMIT,      1'b1};
         STEP_EMIT:      cw = '{OP_EMIT,      COND_ALWAYS,   STEP_WAIT,      1'b0};
         STEP_EMIT_ZERO: cw = '{OP_EMIT_ZERO, COND_ALWAYS,   STEP_WAIT,      1'b0};
         default:        cw = '{OP_NONE,      COND_ALWAYS,   STEP_WAIT,      1'b0};
      endcase
      return cw;
   endfunction

endpackage

@@ hw/rtl/fng_div.sv @@
// ----------------------------------------------------------------------------
// fng_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fng_div #(
   parameter int DATA_WIDTH = fng_pkg::DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output logic                  busy,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);

   localparam int CNT_WIDTH = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] div_ff, div_in;
   logic [DATA_WIDTH:0]   trial;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_WIDTH-1]};
      fits    = trial >= {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(DATA_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DATA_WIDTH'(trial - {1'b0, div_ff}) : trial[DATA_WIDTH-1:0];
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/fng_seq.sv @@
// ----------------------------------------------------------------------------
// fng_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module fng_seq (
   input  logic                clock,
   input  logic                reset,
   input  fng_pkg::status_type status,
   output fng_pkg::op_type     op,
   output logic                busy
);

   fng_pkg::step_type      pc_ff, pc_in;
   fng_pkg::ctrl_word_type cw;
   logic                   cond_ok;

   always_comb begin
      cw = fng_pkg::rom(pc_ff);
      unique case (cw.cond)
         fng_pkg::COND_ALWAYS:   cond_ok = 1'b1;
         fng_pkg::COND_START:    cond_ok = status.start;
         fng_pkg::COND_NUM_ZERO: cond_ok = status.num_zero;
         fng_pkg::COND_B_ZERO:   cond_ok = status.b_zero;
         fng_pkg::COND_DIV_DONE: cond_ok = status.div_done;
         default:                cond_ok = 1'b0;
      endcase
      if (cond_ok) begin
         op    = cw.op;
         pc_in = cw.target;
      end else begin
         op    = fng_pkg::OP_NONE;
         pc_in = cw.hold ? pc_ff : pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= fng_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign busy = pc_ff != fng_pkg::STEP_WAIT;

endmodule

@@ hw/rtl/fraction_normalize_gcd_top.sv @@
// ----------------------------------------------------------------------------
// fraction_normalize_gcd_top
// Reduces a signed fraction to lowest terms with a non-negative denominator.
//
//   channel  ports                               handshake
//   request  req_num_in, req_den_in              start & !busy
//   response rsp_num_out, rsp_den_out,           rsp_valid, one cycle
//            rsp_den_zero
//
// Zero numerator: the test step jumps straight to the zero response.
// Otherwise each Euclid remainder step runs one division, then the numerator
// and the denominator are each divided by the gcd; all divisions share one
// divider that produces one quotient bit per cycle.
// Synchronous reset returns the sequencer to its wait step.
// One transaction at a time; busy stays high until the response strobe.
// ----------------------------------------------------------------------------
module fraction_normalize_gcd_top #(
   parameter int DATA_WIDTH = fng_pkg::DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_num_in,
   input  logic signed [DATA_WIDTH-1:0] req_den_in,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_num_out,
   output logic        [DATA_WIDTH-2:0] rsp_den_out,
   output logic                         rsp_den_zero
);

   localparam logic [DATA_WIDTH-1:0] MAX_MAG = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   fng_pkg::op_type     op;
   fng_pkg::status_type status;

   logic [DATA_WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [DATA_WIDTH-1:0] mn_ff, mn_in, md_ff, md_in;
   logic [DATA_WIDTH-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic                  nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-2:0] den_ff, den_in;
   logic                  dz_ff, dz_in;

   logic [DATA_WIDTH-1:0] num_mag, den_mag, rn_sat, rd_sat;
   logic                  neg, div_start, div_busy;
   logic [DATA_WIDTH-1:0] div_dividend, div_divisor, div_quo, div_rem;

   fng_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   fng_div #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      status.start    = start;
      status.num_zero = mn_ff == '0;
      status.b_zero   = b_ff == '0;
      status.div_done = !div_busy;
   end

   always_comb begin
      num_mag = req_num_in[DATA_WIDTH-1] ? (~req_num_in + 1'b1) : req_num_in;
      den_mag = req_den_in[DATA_WIDTH-1] ? (~req_den_in + 1'b1) : req_den_in;
      rn_sat  = rn_ff[DATA_WIDTH-1] ? MAX_MAG : rn_ff;
      rd_sat  = rd_ff[DATA_WIDTH-1] ? MAX_MAG : rd_ff;
      neg     = (md_ff != '0) ? (nneg_ff ^ dneg_ff) : nneg_ff;

      div_start    = 1'b0;
      div_dividend = a_ff;
      div_divisor  = b_ff;

      a_in     = a_ff;
      b_in     = b_ff;
      mn_in    = mn_ff;
      md_in    = md_ff;
      nneg_in  = nneg_ff;
      dneg_in  = dneg_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      valid_in = 1'b0;
      num_in   = num_ff;
      den_in   = den_ff;
      dz_in    = dz_ff;

      case (op)
         fng_pkg::OP_LOAD: begin
            a_in    = num_mag;
            b_in    = den_mag;
            mn_in   = num_mag;
            md_in   = den_mag;
            nneg_in = req_num_in[DATA_WIDTH-1];
            dneg_in = req_den_in[DATA_WIDTH-1];
         end
         fng_pkg::OP_DIV_AB: begin
            div_start = 1'b1;
         end
         fng_pkg::OP_EUCLID: begin
            a_in = b_ff;
            b_in = div_rem;
         end
         fng_pkg::OP_DIV_NG: begin
            div_start    = 1'b1;
            div_dividend = mn_ff;
            div_divisor  = a_ff;
         end
         fng_pkg::OP_SAVE_RN: begin
            rn_in = div_quo;
         end
         fng_pkg::OP_DIV_DG: begin
            div_start    = 1'b1;
            div_dividend = md_ff;
            div_divisor  = a_ff;
         end
         fng_pkg::OP_SAVE_RD: begin
            rd_in = div_quo;
         end
         fng_pkg::OP_EMIT: begin
            valid_in = 1'b1;
            num_in   = neg ? (~rn_sat + 1'b1) : rn_sat;
            den_in   = rd_sat[DATA_WIDTH-2:0];
            dz_in    = md_ff == '0;
         end
         fng_pkg::OP_EMIT_ZERO: begin
            valid_in = 1'b1;
            num_in   = '0;
            den_in   = (DATA_WIDTH-1)'(1);
            dz_in    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      mn_ff   <= mn_in;
      md_ff   <= md_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      rn_ff   <= rn_in;
      rd_ff   <= rd_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      dz_ff   <= dz_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_num_out  = num_ff;
   assign rsp_den_out  = den_ff;
   assign rsp_den_zero = dz_ff;

endmodule
